// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the core RTL.
// Each macro expands to one labeled concurrent assertion that reports with $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: assertion failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/core/spiee_pkg.sv -----
// Shared types and constants for the SPI serial EEPROM slave core.
// Used by every core module except spiee_ram; depends on nothing else.
package spiee_pkg;

  localparam int BYTE_W        = 8;
  localparam int REQ_W         = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int MEM_DEPTH_DEF = 65536;
  localparam int PAGE_SIZE_DEF = 64;
  localparam int OUTQ_DEPTH    = 4;

  // Bus event kinds carried with each input word.
  localparam logic [REQ_W-1:0] REQ_SELECT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_XFER    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_READ_OP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_OP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_OP = 2'd2;

  localparam logic [BYTE_W-1:0] READ_OP_RST   = 8'd3;
  localparam logic [BYTE_W-1:0] WRITE_OP_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] STATUS_OP_RST = 8'd5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RD_HI,
    PH_RD_LO,
    PH_RD_DATA,
    PH_WR_HI,
    PH_WR_LO,
    PH_WR_DATA,
    PH_STATUS
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_op;
    logic [BYTE_W-1:0] write_op;
    logic [BYTE_W-1:0] status_op;
  } opcodes_t;

endpackage

// ----- rtl/core/spi_eeprom_slave_core.sv -----
// Top level of the SPI serial EEPROM slave core.
// Depends on spiee_pkg, spiee_decode, spiee_ram, spiee_outq and assert_macros.svh.
//
// Each input word is one bus event: s_tuser gives the kind (select asserted,
// select released, byte transfer) and s_tdata the byte from the master. Every
// input word produces exactly one output word on m_tdata, the byte returned to
// the master. Opcodes are set through the cfg write channel, which is always
// ready and should be used only while the core is idle.
// An accepted word passes the input register, the decoder's result register and
// the output queue before its output is valid. Throughput is one word per cycle
// while s_tready is high: the decoder updates its state and the EEPROM array takes
// one read or write per word. After reset the array is cleared one byte per cycle
// over all MEM_DEPTH addresses (65536 by default); s_tready stays low during that time.
// Words in flight are counted against a 4-entry output queue. When the
// receiver stalls, the queue fills and s_tready drops once four words are
// pending, so no word is lost.
`include "assert_macros.svh"

module spi_eeprom_slave_core
  import spiee_pkg::*;
#(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF,
  parameter int PAGE_SIZE = PAGE_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] mosi_byte
  input  logic [REQ_W-1:0]     s_tuser,   // [1:0] req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,   // [7:0] miso_byte
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int QCW = $clog2(OUTQ_DEPTH + 1);

  opcodes_t          opcodes;
  logic              valid_a;
  logic [REQ_W-1:0]  req_a;
  logic [BYTE_W-1:0] mosi_a;
  logic              clearing;
  logic [AW-1:0]     clr_addr;
  logic [QCW-1:0]    pending, pending_next;
  logic              s_accept;
  logic              m_accept;

  logic [AW-1:0]     dec_addr;
  logic              dec_we;
  logic [BYTE_W-1:0] dec_wdata;
  logic              res_valid;
  logic              res_read;

  logic [AW-1:0]     ram_addr;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] res_byte;

  assign cfg_ready = 1'b1;
  assign s_tready  = !clearing && (pending < QCW'(OUTQ_DEPTH));
  assign s_accept  = s_tvalid && s_tready;
  assign m_accept  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      opcodes.read_op   <= READ_OP_RST;
      opcodes.write_op  <= WRITE_OP_RST;
      opcodes.status_op <= STATUS_OP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_READ_OP:   opcodes.read_op   <= cfg_data;
        CFG_WRITE_OP:  opcodes.write_op  <= cfg_data;
        CFG_STATUS_OP: opcodes.status_op <= cfg_data;
        default:       opcodes           <= opcodes;
      endcase
    end
  end

  always_comb begin
    pending_next = pending;
    if (s_accept && !m_accept) begin
      pending_next = pending + QCW'(1);
    end else if (m_accept && !s_accept) begin
      pending_next = pending - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a  <= 1'b0;
      pending  <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      valid_a <= s_accept;
      pending <= pending_next;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(MEM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
    if (s_accept) begin
      req_a  <= s_tuser;
      mosi_a <= s_tdata;
    end
  end

  spiee_decode #(
    .MEM_DEPTH (MEM_DEPTH),
    .PAGE_SIZE (PAGE_SIZE)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (valid_a),
    .req_type   (req_a),
    .mosi_byte  (mosi_a),
    .opcodes    (opcodes),
    .mem_addr   (dec_addr),
    .mem_we     (dec_we),
    .mem_wdata  (dec_wdata),
    .res_valid  (res_valid),
    .res_read   (res_read)
  );

  assign ram_addr  = clearing ? clr_addr : dec_addr;
  assign ram_we    = clearing || dec_we;
  assign ram_wdata = clearing ? '0 : dec_wdata;

  spiee_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign res_byte = res_read ? ram_rdata : '0;

  spiee_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_byte),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  `ASSERT_ALWAYS(a_pending_bound, clk, rst, pending <= QCW'(OUTQ_DEPTH))
  `ASSERT_IMPLIES(a_no_accept_clear, clk, rst, clearing, !s_tready && !valid_a)
  `ASSERT_IMPLIES(a_deliver_pending, clk, rst, m_accept, pending != '0)
  `ASSERT_IMPLIES(a_write_not_clear, clk, rst, dec_we, !clearing && valid_a)

endmodule

// ----- rtl/core/spiee_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies; used for the EEPROM array.
module spiee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/spiee_decode.sv -----
// Command decoder: select tracking, command phase, address and page offset.
// Depends on spiee_pkg; drives the RAM request for one word per cycle.
module spiee_decode
  import spiee_pkg::*;
#(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF,
  parameter int PAGE_SIZE = PAGE_SIZE_DEF,
  localparam int AW = $clog2(MEM_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [BYTE_W-1:0] mosi_byte,
  input  opcodes_t          opcodes,
  output logic [AW-1:0]     mem_addr,
  output logic              mem_we,
  output logic [BYTE_W-1:0] mem_wdata,
  output logic              res_valid,
  output logic              res_read
);

  localparam int OW = (PAGE_SIZE > 1) ? $clog2(PAGE_SIZE) : 1;

  phase_t        phase, phase_next;
  logic          selected, selected_next;
  logic [AW-1:0] hi_mod, hi_mod_next;
  logic [AW-1:0] base_mod, base_mod_next;
  logic [AW-1:0] cur_index, cur_index_next;
  logic [OW-1:0] page_offset, page_offset_next;

  logic [AW-1:0] hi_tab [256];
  logic [AW-1:0] lo_tab [256];
  logic [AW:0]   base_sum;
  logic [AW:0]   idx_inc;
  logic          xfer;
  logic          rd;

  // Residues of the address bytes modulo the memory depth.
  for (genvar g = 0; g < 256; g++) begin : g_tab
    assign hi_tab[g] = AW'((g * 256) % MEM_DEPTH);
    assign lo_tab[g] = AW'(g % MEM_DEPTH);
  end

  assign base_sum = {1'b0, hi_mod} + {1'b0, lo_tab[mosi_byte]};
  assign idx_inc  = {1'b0, cur_index} + (AW+1)'(1);
  assign xfer     = item_valid && (req_type == REQ_XFER) && selected;
  assign rd       = xfer && (phase == PH_RD_DATA);

  assign mem_addr  = cur_index;
  assign mem_we    = xfer && (phase == PH_WR_DATA);
  assign mem_wdata = mosi_byte;

  always_comb begin
    phase_next       = phase;
    selected_next    = selected;
    hi_mod_next      = hi_mod;
    base_mod_next    = base_mod;
    cur_index_next   = cur_index;
    page_offset_next = page_offset;
    if (item_valid && (req_type == REQ_SELECT)) begin
      selected_next = 1'b1;
      phase_next    = PH_IDLE;
    end else if (item_valid && (req_type == REQ_RELEASE)) begin
      selected_next = 1'b0;
    end else if (xfer) begin
      case (phase)
        PH_IDLE: begin
          if (mosi_byte == opcodes.read_op) begin
            phase_next = PH_RD_HI;
          end else if (mosi_byte == opcodes.write_op) begin
            phase_next = PH_WR_HI;
          end else if (mosi_byte == opcodes.status_op) begin
            phase_next = PH_STATUS;
          end
        end
        PH_RD_HI, PH_WR_HI: begin
          hi_mod_next = hi_tab[mosi_byte];
          phase_next  = (phase == PH_RD_HI) ? PH_RD_LO : PH_WR_LO;
        end
        PH_RD_LO, PH_WR_LO: begin
          if (base_sum >= (AW+1)'(MEM_DEPTH)) begin
            base_mod_next = AW'(base_sum - (AW+1)'(MEM_DEPTH));
          end else begin
            base_mod_next = base_sum[AW-1:0];
          end
          cur_index_next   = base_mod_next;
          page_offset_next = '0;
          phase_next       = (phase == PH_RD_LO) ? PH_RD_DATA : PH_WR_DATA;
        end
        PH_RD_DATA, PH_WR_DATA: begin
          // At the end of the page the access returns to the base address.
          if (page_offset == OW'(PAGE_SIZE - 1)) begin
            page_offset_next = '0;
            cur_index_next   = base_mod;
          end else begin
            page_offset_next = page_offset + OW'(1);
            if (idx_inc == (AW+1)'(MEM_DEPTH)) begin
              cur_index_next = '0;
            end else begin
              cur_index_next = idx_inc[AW-1:0];
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      selected  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      selected  <= selected_next;
      res_valid <= item_valid;
    end
    hi_mod      <= hi_mod_next;
    base_mod    <= base_mod_next;
    cur_index   <= cur_index_next;
    page_offset <= page_offset_next;
    res_read    <= rd;
  end

endmodule

// ----- rtl/core/spiee_outq.sv -----
// Output queue that holds result words until the receiver takes them.
// Depends on spiee_pkg for its depth and word width.
module spiee_outq
  import spiee_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [BYTE_W-1:0] push_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata
);

  localparam int QAW = $clog2(OUTQ_DEPTH);
  localparam int QCW = $clog2(OUTQ_DEPTH + 1);

  logic [BYTE_W-1:0] store [OUTQ_DEPTH];
  logic [QAW-1:0]    head, head_next;
  logic [QAW-1:0]    tail, tail_next;
  logic [QCW-1:0]    fill, fill_next;
  logic              pop;

  assign m_tvalid = (fill != '0);
  assign m_tdata  = store[head];
  assign pop      = m_tvalid && m_tready;

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    if (pop) begin
      head_next = (head == QAW'(OUTQ_DEPTH - 1)) ? '0 : head + QAW'(1);
    end
    if (push) begin
      tail_next = (tail == QAW'(OUTQ_DEPTH - 1)) ? '0 : tail + QAW'(1);
    end
    if (push && !pop) begin
      fill_next = fill + QCW'(1);
    end else if (pop && !push) begin
      fill_next = fill - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
    if (push) begin
      store[tail] <= push_data;
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for spi_eeprom_slave_core: directed bus events, opcode settings and
// random read, write and status sessions. Depends on spiee_pkg and the core RTL only; results
// are predicted by an in-bench EEPROM image and compared word by word.
module testbench;
  import spiee_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 9;
  localparam int LATENCY_WAIT = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int MEM_DEPTH    = MEM_DEPTH_DEF;
  localparam int PAGE_SIZE    = PAGE_SIZE_DEF;
  localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata   = '0;
  logic [REQ_W-1:0]     s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [BYTE_W-1:0]    m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data  = '0;

  spi_eeprom_slave_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted state of the EEPROM slave.
  opcodes_t          opcodes;
  logic              chip_sel;
  phase_t            cmd_phase;
  logic [15:0]       addr_base;
  int                page_ofs;
  logic [BYTE_W-1:0] eeprom_img [MEM_DEPTH];

  logic [BYTE_W-1:0] miso_expect_q [$];
  logic [BYTE_W-1:0] miso_want;
  int                mismatches    = 0;
  int                words_sent    = 0;
  int                words_checked = 0;
  int                data_reads    = 0;
  int                cfg_writes    = 0;
  int                cycle_cnt     = 0;
  int                burst_left    = 0;
  bit                gaps_on       = 1'b1;
  int                rx_mode       = 0;
  int                rx_hold       = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding.", cycle_cnt,
               miso_expect_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0d] MISMATCH: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  task automatic reset_model;
    opcodes   = '{read_op: READ_OP_RST, write_op: WRITE_OP_RST, status_op: STATUS_OP_RST};
    chip_sel  = 1'b0;
    cmd_phase = PH_IDLE;
    addr_base = '0;
    page_ofs  = 0;
    for (int i = 0; i < MEM_DEPTH; i++) eeprom_img[i] = '0;
  endtask

  function automatic logic [BYTE_W-1:0] predict_miso(input logic [REQ_W-1:0] kind,
                                                      input logic [BYTE_W-1:0] mosi);
    logic [BYTE_W-1:0] miso;
    int                slot;
    miso = '0;
    slot = (int'(addr_base) + page_ofs) % MEM_DEPTH;
    case (kind)
      REQ_SELECT: begin
        chip_sel  = 1'b1;
        cmd_phase = PH_IDLE;
      end
      REQ_RELEASE: chip_sel = 1'b0;
      REQ_XFER: if (chip_sel) begin
        case (cmd_phase)
          PH_IDLE: begin
            if (mosi == opcodes.read_op) cmd_phase = PH_RD_HI;
            else if (mosi == opcodes.write_op) cmd_phase = PH_WR_HI;
            else if (mosi == opcodes.status_op) cmd_phase = PH_STATUS;
          end
          PH_RD_HI, PH_WR_HI: begin
            addr_base = {mosi, 8'h00};
            cmd_phase = (cmd_phase == PH_RD_HI) ? PH_RD_LO : PH_WR_LO;
          end
          PH_RD_LO, PH_WR_LO: begin
            addr_base = addr_base | {8'h00, mosi};
            page_ofs  = 0;
            cmd_phase = (cmd_phase == PH_RD_LO) ? PH_RD_DATA : PH_WR_DATA;
          end
          PH_RD_DATA: begin
            miso     = eeprom_img[slot];
            page_ofs = (page_ofs + 1) % PAGE_SIZE;
            data_reads++;
          end
          PH_WR_DATA: begin
            eeprom_img[slot] = mosi;
            page_ofs         = (page_ofs + 1) % PAGE_SIZE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return miso;
  endfunction

  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [BYTE_W-1:0] mosi);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= mosi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    miso_expect_q.push_back(predict_miso(kind, mosi));
    words_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (miso_expect_q.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_READ_OP:   opcodes.read_op   = val;
      CFG_WRITE_OP:  opcodes.write_op  = val;
      CFG_STATUS_OP: opcodes.status_op = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_opcodes(input logic [BYTE_W-1:0] rd, input logic [BYTE_W-1:0] wr,
                             input logic [BYTE_W-1:0] st);
    drain();
    cfg_write(CFG_READ_OP, rd);
    cfg_write(CFG_WRITE_OP, wr);
    cfg_write(CFG_STATUS_OP, st);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_command(input logic [BYTE_W-1:0] op, input logic [15:0] addr,
                             input int nbytes);
    send_word(REQ_SELECT, 8'($urandom));
    send_word(REQ_XFER, op);
    send_word(REQ_XFER, addr[15:8]);
    send_word(REQ_XFER, addr[7:0]);
    repeat (nbytes) send_word(REQ_XFER, 8'($urandom));
  endtask

  task automatic test_idle_events;
    send_word(REQ_XFER, 8'hFF);
    send_word(REQ_UNUSED, 8'h00);
    send_word(REQ_SELECT, 8'h00);
    send_word(REQ_SELECT, 8'hFF);
    send_word(REQ_XFER, 8'h00);
    send_word(REQ_XFER, STATUS_OP_RST);
    send_word(REQ_XFER, READ_OP_RST);
    send_word(REQ_XFER, 8'hFF);
  endtask

  task automatic test_write_read_wrap;
    send_word(REQ_SELECT, 8'h00);
    send_word(REQ_XFER, WRITE_OP_RST);
    send_word(REQ_XFER, 8'hFF);
    send_word(REQ_XFER, 8'hFF);
    send_word(REQ_XFER, 8'hFF);
    send_word(REQ_XFER, 8'h5A);
    send_word(REQ_SELECT, 8'h00);
    send_word(REQ_XFER, READ_OP_RST);
    send_word(REQ_XFER, 8'hFF);
    send_word(REQ_XFER, 8'hFF);
    send_word(REQ_XFER, 8'h00);
    send_word(REQ_XFER, 8'h00);
    send_word(REQ_RELEASE, 8'h00);
  endtask

  task automatic test_opcode_priority;
    set_opcodes(8'h42, 8'h42, 8'h42);
    run_command(opcodes.read_op, 16'h0010, 1);
    set_opcodes(8'h10, 8'h42, 8'h42);
    send_word(REQ_SELECT, 8'h00);
    send_word(REQ_XFER, 8'h42);
    send_word(REQ_XFER, 8'h00);
    send_word(REQ_XFER, 8'h10);
    send_word(REQ_XFER, 8'h66);
    drain();
    cfg_write(CFG_UNUSED, 8'h66);
    cfg_valid <= 1'b0;
    run_command(8'h10, 16'h0010, 1);
  endtask

  task automatic test_random_traffic(input int n_items);
    int          stop_at;
    int          pick;
    int          nbytes;
    logic [15:0] addr;
    stop_at = words_sent + n_items;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
        0:       addr[15:8] = 8'h00;
        1:       addr[15:8] = 8'hFF;
        2:       addr[15:8] = 8'h5A;
        default: addr[15:8] = 8'($urandom);
      endcase
      addr[7:0] = $urandom_range(0, 1) ? {2'b11, 6'($urandom)} : 8'($urandom);
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      if (pick < 40) run_command(opcodes.read_op, addr, nbytes);
      else if (pick < 75) run_command(opcodes.write_op, addr, nbytes);
      else if (pick < 83) run_command(opcodes.status_op, addr, $urandom_range(0, 3));
      else repeat ($urandom_range(1, 6)) send_word(2'($urandom), 8'($urandom));
      if ($urandom_range(0, 4) != 0) send_word(REQ_RELEASE, 8'($urandom));
      if ($urandom_range(0, 9) == 0) gaps_on = !gaps_on;
    end
  endtask

  always @(posedge clk) begin
    if (cycle_cnt % 300 == 0) rx_mode = $urandom_range(0, 2);
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 20);
          m_tready <= (rx_hold == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (miso_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word, miso_byte %02h", m_tdata));
      end else begin
        miso_want = miso_expect_q.pop_front();
        if (m_tdata !== miso_want)
          report_mismatch($sformatf("miso_byte %02h, expected %02h", m_tdata, miso_want));
        words_checked++;
      end
    end
  end

  initial begin
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_idle_events();
    test_write_read_wrap();
    test_opcode_priority();
    set_opcodes(READ_OP_RST, WRITE_OP_RST, STATUS_OP_RST);
    test_random_traffic(RANDOM_ITEMS / 4);
    set_opcodes(8'hFF, 8'h00, 8'h80);
    test_random_traffic(RANDOM_ITEMS / 4);
    set_opcodes(8'($urandom), 8'($urandom), 8'($urandom));
    test_random_traffic(RANDOM_ITEMS / 4);
    set_opcodes(8'h00, 8'hFF, 8'hFF);
    test_random_traffic(RANDOM_ITEMS / 4);
    drain();
    $display("Sent %0d bus words under %0d register writes; %0d of them read array data.",
             words_sent, cfg_writes, data_reads);
    $display("Checked %0d returned bytes, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0 && miso_expect_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- spi_eeprom_slave_core.f -----
+incdir+rtl/core
rtl/core/spiee_pkg.sv
rtl/core/spiee_ram.sv
rtl/core/spiee_decode.sv
rtl/core/spiee_outq.sv
rtl/core/spi_eeprom_slave_core.sv
verif/testbench.sv
